[rtl/whs_pkg.sv]
// Shared constants, register index codes and the CORDIC arctangent table for
// the waypoint heading steering block. No dependencies.
package whs_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int TABLE_FRAC      = 16;
  localparam int TABLE_LEN       = 24;
  localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  localparam int POS_W = 16;
  localparam int DXY_W = POS_W + 1;
  localparam int XY_W  = DXY_W + TABLE_FRAC + 3;
  localparam int Z_W   = 27;
  localparam int RND_SHIFT = TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam int R_W   = Z_W - RND_SHIFT;
  localparam int ANG_W = 15;
  localparam int D_W   = ANG_W + 2;
  localparam int SPD_W = 16;
  localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
  localparam int HALF_TURN_Q = 180 << TABLE_FRAC;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_X     = 3'd0,
    REG_TARGET_Y     = 3'd1,
    REG_DRIVING_EN   = 3'd2,
    REG_FACING_TOL   = 3'd3,
    REG_FORWARD_SPD  = 3'd4,
    REG_TURN_SPD     = 3'd5
  } cfg_reg_t;

  // atan(2^-i) in degrees, 16 fractional bits, rounded
  function automatic logic signed [Z_W-1:0] atan_q16(input int i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:  a = Z_W'(2949120);
      1:  a = Z_W'(1740967);
      2:  a = Z_W'(919879);
      3:  a = Z_W'(466945);
      4:  a = Z_W'(234379);
      5:  a = Z_W'(117304);
      6:  a = Z_W'(58666);
      7:  a = Z_W'(29335);
      8:  a = Z_W'(14668);
      9:  a = Z_W'(7334);
      10: a = Z_W'(3667);
      11: a = Z_W'(1833);
      12: a = Z_W'(917);
      13: a = Z_W'(458);
      14: a = Z_W'(229);
      15: a = Z_W'(115);
      16: a = Z_W'(57);
      17: a = Z_W'(29);
      18: a = Z_W'(14);
      19: a = Z_W'(7);
      20: a = Z_W'(4);
      21: a = Z_W'(2);
      22: a = Z_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[rtl/waypoint_heading_steer.sv]
// Waypoint heading steering: pipelined CORDIC bearing plus bang-bang turn logic.
// Depends on whs_pkg for constants, register codes and the arctangent table.
// Start to done: input, pre-rotation, CORDIC, round, fold, diff, done registers.
// Throughput: one pose per cycle; busy is always low, one CORDIC stage per step.
// Reset clears all valid bits and loads the register defaults; the receiver cannot stall.
module waypoint_heading_steer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [whs_pkg::POS_W-1:0]     robot_x,
  input  logic signed [whs_pkg::POS_W-1:0]     robot_y,
  input  logic        [whs_pkg::ANG_W-1:0]     robot_yaw,
  output logic                                 done,
  output logic        [whs_pkg::SPD_W-1:0]     linear_speed,
  output logic signed [whs_pkg::SPD_W:0]       angular_speed,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [whs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [whs_pkg::SPD_W-1:0]     cfg_data
);

  localparam int STEPS = whs_pkg::STEPS;
  localparam int XY_W  = whs_pkg::XY_W;
  localparam int Z_W   = whs_pkg::Z_W;
  localparam int R_W   = whs_pkg::R_W;
  localparam int ANG_W = whs_pkg::ANG_W;
  localparam int D_W   = whs_pkg::D_W;
  localparam int DXY_W = whs_pkg::DXY_W;
  localparam int SPD_W = whs_pkg::SPD_W;
  localparam int EXT_W = XY_W - DXY_W - whs_pkg::TABLE_FRAC;

  // configuration registers
  logic signed [whs_pkg::POS_W-1:0] target_x;
  logic signed [whs_pkg::POS_W-1:0] target_y;
  logic                             driving_enabled;
  logic        [ANG_W-1:0]          facing_tolerance;
  logic        [SPD_W-1:0]          forward_speed;
  logic        [SPD_W-1:0]          turn_speed;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x         <= '1;
      target_y         <= '1;
      driving_enabled  <= 1'b0;
      facing_tolerance <= ANG_W'(320);
      forward_speed    <= '0;
      turn_speed       <= '0;
    end else if (cfg_valid) begin
      unique case (whs_pkg::cfg_reg_t'(cfg_index))
        whs_pkg::REG_TARGET_X:    target_x         <= cfg_data;
        whs_pkg::REG_TARGET_Y:    target_y         <= cfg_data;
        whs_pkg::REG_DRIVING_EN:  driving_enabled  <= cfg_data[0];
        whs_pkg::REG_FACING_TOL:  facing_tolerance <= cfg_data[ANG_W-1:0];
        whs_pkg::REG_FORWARD_SPD: forward_speed    <= cfg_data;
        whs_pkg::REG_TURN_SPD:    turn_speed       <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage: differences
  logic                    in_vld;
  logic signed [DXY_W-1:0] dx, dy;
  logic        [ANG_W-1:0] in_yaw;

  // CORDIC stages, index 0 is after pre-rotation
  logic        [STEPS:0]   vld;
  logic signed [XY_W-1:0]  xs   [0:STEPS];
  logic signed [XY_W-1:0]  ys   [0:STEPS];
  logic signed [Z_W-1:0]   zs   [0:STEPS];
  logic        [STEPS:0]   zero;
  logic        [ANG_W-1:0] yaws [0:STEPS];

  // post stages
  logic                    rnd_vld, fold_vld, diff_vld;
  logic signed [R_W-1:0]   rnd;
  logic                    rnd_zero;
  logic        [ANG_W-1:0] rnd_yaw, fold_yaw;
  logic        [ANG_W-1:0] bearing;
  logic signed [D_W-1:0]   diff;

  logic signed [DXY_W-1:0] dx_n, dy_n;
  logic signed [Z_W-1:0]   z_rnd;
  logic signed [R_W-1:0]   fold_val;
  logic signed [D_W-1:0]   diff_abs, left, right;
  logic signed [D_W-1:0]   full_d;

  assign dx_n   = dx[DXY_W-1] ? -dx : dx;
  assign dy_n   = dx[DXY_W-1] ? -dy : dy;
  assign z_rnd  = (zs[STEPS] + Z_W'(1 << (whs_pkg::RND_SHIFT - 1))) >>> whs_pkg::RND_SHIFT;
  assign full_d = D_W'(whs_pkg::FULL_TURN);

  always_comb begin
    if (rnd < 0) begin
      fold_val = rnd + R_W'(whs_pkg::FULL_TURN);
    end else if (rnd >= R_W'(whs_pkg::FULL_TURN)) begin
      fold_val = rnd - R_W'(whs_pkg::FULL_TURN);
    end else begin
      fold_val = rnd;
    end
    diff_abs = diff[D_W-1] ? -diff : diff;
    left     = diff[D_W-1] ? diff + full_d : diff;
    right    = (-diff < 0) ? full_d - diff : -diff;
  end

  always_ff @(posedge clk) begin
    dx     <= {target_x[whs_pkg::POS_W-1], target_x} - {robot_x[whs_pkg::POS_W-1], robot_x};
    dy     <= {robot_y[whs_pkg::POS_W-1], robot_y} - {target_y[whs_pkg::POS_W-1], target_y};
    in_yaw <= robot_yaw;

    xs[0]   <= {{EXT_W{dx_n[DXY_W-1]}}, dx_n, {whs_pkg::TABLE_FRAC{1'b0}}};
    ys[0]   <= {{EXT_W{dy_n[DXY_W-1]}}, dy_n, {whs_pkg::TABLE_FRAC{1'b0}}};
    zs[0]   <= dx[DXY_W-1] ? Z_W'(whs_pkg::HALF_TURN_Q) : '0;
    zero[0] <= (dx == '0) && (dy == '0);
    yaws[0] <= in_yaw;

    for (int i = 0; i < STEPS; i++) begin
      if (!ys[i][XY_W-1]) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + whs_pkg::atan_q16(i);
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - whs_pkg::atan_q16(i);
      end
      zero[i+1] <= zero[i];
      yaws[i+1] <= yaws[i];
    end

    rnd      <= z_rnd[R_W-1:0];
    rnd_zero <= zero[STEPS];
    rnd_yaw  <= yaws[STEPS];

    bearing  <= rnd_zero ? '0 : fold_val[ANG_W-1:0];
    fold_yaw <= rnd_yaw;

    diff <= D_W'(bearing) - D_W'(fold_yaw);

    linear_speed  <= (diff_abs <= D_W'(facing_tolerance)) ? forward_speed : '0;
    if (diff_abs <= D_W'(facing_tolerance)) begin
      angular_speed <= '0;
    end else if (left < right) begin
      angular_speed <= {1'b0, turn_speed};
    end else begin
      angular_speed <= -{1'b0, turn_speed};
    end

    if (rst) begin
      in_vld   <= 1'b0;
      vld      <= '0;
      rnd_vld  <= 1'b0;
      fold_vld <= 1'b0;
      diff_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_vld   <= start && !busy && driving_enabled;
      vld      <= {vld[STEPS-1:0], in_vld};
      rnd_vld  <= vld[STEPS];
      fold_vld <= rnd_vld;
      diff_vld <= fold_vld;
      done     <= diff_vld;
    end
  end

endmodule
